// File: design/particle_integrate_and_bound_defines.svh
// Assertion macros for the particle integrate-and-bound block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef PARTICLE_INTEGRATE_AND_BOUND_DEFINES_SVH
`define PARTICLE_INTEGRATE_AND_BOUND_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define PIB_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("particle_integrate_and_bound: invariant violated");

// Checks that a trigger is followed by a condition in the following cycle.
`define PIB_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("particle_integrate_and_bound: sequence violated");

`else

`define PIB_ASSERT_ALWAYS(label, expr)
`define PIB_ASSERT_NEXT(label, trig, expr)

`endif

`endif

// File: design/pib_pkg.sv
// Shared types, constants and fixed-point helpers for the particle
// integrate-and-bound block. No dependencies.
package pib_pkg;

    // Number of register stages in the datapath.
    localparam int NUM_STAGES = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOWER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_UPPER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOWER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_UPPER     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOWER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_UPPER     = 3'd7;

    // Register reset values.
    localparam logic [15:0]        TIME_STEP_RST   = 16'd655;
    localparam logic [16:0]        RESTITUTION_RST = 17'd32768;
    localparam logic signed [31:0] LOWER_RST       = 32'sd0;
    localparam logic signed [31:0] UPPER_RST       = 32'sd65536;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] smooth_vx;
        logic signed [31:0] smooth_vy;
        logic signed [31:0] smooth_vz;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_smooth_vx;
        logic signed [31:0] new_smooth_vy;
        logic signed [31:0] new_smooth_vz;
    } result_t;

    // Per-stage load enables and occupancy, from the pipeline control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

    // Saturates a 34-bit signed sum to the Q16.16 range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if ((x[33:31] == 3'b000) || (x[33:31] == 3'b111)) begin
            r = x[31:0];
        end else if (x[33]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    // Limits an unsigned 32-bit magnitude to 2^31 so that its negation fits.
    function automatic logic [31:0] cap_neg(input logic [31:0] m);
        logic [31:0] r;
        if (m[31] && (m[30:0] != 31'd0)) begin
            r = 32'h8000_0000;
        end else begin
            r = m;
        end
        return r;
    endfunction

endpackage

// File: design/pib_pipe_ctrl.sv
// Valid/ready control for the datapath stages: occupancy bits and load enables.
// Depends on pib_pkg.
module pib_pipe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    output logic               down_valid,
    input  logic               down_ready,
    output pib_pkg::pipe_ctrl_t ctrl
);
    import pib_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;
    logic [NUM_STAGES-1:0] feed;

    // A stage may load when it is empty or the stage after it moves on.
    always_comb
    begin
        rdy[NUM_STAGES] = down_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
    end

    // Each stage takes the occupancy of the stage before it when it loads.
    always_comb
    begin
        feed       = {valid_reg[NUM_STAGES-2:0], up_valid};
        valid_next = (rdy[NUM_STAGES-1:0] & feed) | (~rdy[NUM_STAGES-1:0] & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load  = rdy[NUM_STAGES-1:0];
    assign ctrl.valid = valid_reg;
    assign up_ready   = rdy[0];
    assign down_valid = valid_reg[NUM_STAGES-1];

endmodule

// File: design/pib_axis.sv
// Eight-stage datapath for one axis: Euler step, smoothing and box bounce.
// Depends on pib_pkg; stage loads come from pib_pipe_ctrl.
module pib_axis (
    input  logic                clk,
    input  pib_pkg::pipe_ctrl_t ctrl,
    input  logic [15:0]         time_step,
    input  logic [16:0]         restitution,
    input  logic signed [31:0]  lower,
    input  logic signed [31:0]  upper,
    input  logic signed [31:0]  pos,
    input  logic signed [31:0]  vel,
    input  logic signed [31:0]  acc,
    input  logic signed [31:0]  smooth,
    output logic signed [31:0]  new_pos,
    output logic signed [31:0]  new_vel,
    output logic signed [31:0]  new_smooth
);
    import pib_pkg::*;

    // Stage 1: acceleration times dt.
    logic signed [31:0] p1_reg, v1_reg, s1_reg;
    logic signed [48:0] pa1_reg, pa1_next;
    // Stage 2: new velocity.
    logic signed [31:0] p2_reg, s2_reg, v2_reg, v2_next;
    // Stage 3: velocity times dt and smoothed velocity.
    logic signed [31:0] p3_reg, v3_reg, sm3_reg;
    logic signed [48:0] pv3_reg, pv3_next;
    logic signed [32:0] smsum;
    // Stage 4: new position and speed magnitude.
    logic signed [31:0] v4_reg, sm4_reg, p4_reg, p4_next;
    logic [31:0]        mag4_reg, mag4_next;
    // Stage 5: wall checks and magnitude times restitution.
    logic signed [31:0] p5_reg, v5_reg, sm5_reg;
    logic               below5_reg, above5_reg;
    logic [47:0]        pm5_reg, pm5_next;
    // Stage 6: scaled bounce magnitude.
    logic signed [31:0] p6_reg, v6_reg, sm6_reg;
    logic               below6_reg, above6_reg;
    logic [30:0]        b6_reg, b6_next;
    logic [31:0]        nm6_reg;
    // Stage 7: second bounce for an inverted box.
    logic signed [31:0] p7_reg, v7_reg, sm7_reg;
    logic               below7_reg, above7_reg;
    logic [30:0]        b7_reg;
    logic [31:0]        nm7_reg;
    logic [47:0]        pb7_reg, pb7_next;
    // Stage 8: output register.
    logic signed [31:0] p8_reg, v8_reg, sm8_reg;
    logic signed [31:0] p8_next, v8_next;
    logic [31:0]        nm2;

    // Datapath logic between the stage registers.
    always_comb
    begin
        pa1_next  = $signed(49'(acc)) * $signed(49'({1'b0, time_step}));
        v2_next   = sat32(34'(v1_reg) + 34'($signed(pa1_reg[48:16])));
        pv3_next  = $signed(49'(v2_reg)) * $signed(49'({1'b0, time_step}));
        smsum     = 33'(s2_reg) + 33'(v2_reg);
        p4_next   = sat32(34'(p3_reg) + 34'($signed(pv3_reg[48:16])));
        mag4_next = v3_reg[31] ? (~v3_reg + 32'd1) : v3_reg;
        pm5_next  = 48'(mag4_reg) * 48'(restitution);
        b6_next   = pm5_reg[47] ? 31'h7FFF_FFFF : pm5_reg[46:16];
        pb7_next  = 48'(b6_reg) * 48'(restitution);
        nm2       = cap_neg(pb7_reg[47:16]);

        // Clamp and bounce; a box with lower above upper ends at upper.
        p8_next = p7_reg;
        v8_next = v7_reg;
        if (below7_reg)
        begin
            if (lower > upper)
            begin
                p8_next = upper;
                v8_next = 32'sd0 - $signed(nm2);
            end
            else
            begin
                p8_next = lower;
                v8_next = $signed({1'b0, b7_reg});
            end
        end
        else if (above7_reg)
        begin
            p8_next = upper;
            v8_next = 32'sd0 - $signed(nm7_reg);
        end
    end

    // Stage registers, each loaded when the control lets it advance.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            p1_reg  <= pos;
            v1_reg  <= vel;
            s1_reg  <= smooth;
            pa1_reg <= pa1_next;
        end
        if (ctrl.load[1])
        begin
            p2_reg <= p1_reg;
            s2_reg <= s1_reg;
            v2_reg <= v2_next;
        end
        if (ctrl.load[2])
        begin
            p3_reg  <= p2_reg;
            v3_reg  <= v2_reg;
            sm3_reg <= smsum[32:1];
            pv3_reg <= pv3_next;
        end
        if (ctrl.load[3])
        begin
            v4_reg   <= v3_reg;
            sm4_reg  <= sm3_reg;
            p4_reg   <= p4_next;
            mag4_reg <= mag4_next;
        end
        if (ctrl.load[4])
        begin
            p5_reg     <= p4_reg;
            v5_reg     <= v4_reg;
            sm5_reg    <= sm4_reg;
            below5_reg <= p4_reg < lower;
            above5_reg <= p4_reg > upper;
            pm5_reg    <= pm5_next;
        end
        if (ctrl.load[5])
        begin
            p6_reg     <= p5_reg;
            v6_reg     <= v5_reg;
            sm6_reg    <= sm5_reg;
            below6_reg <= below5_reg;
            above6_reg <= above5_reg;
            b6_reg     <= b6_next;
            nm6_reg    <= cap_neg(pm5_reg[47:16]);
        end
        if (ctrl.load[6])
        begin
            p7_reg     <= p6_reg;
            v7_reg     <= v6_reg;
            sm7_reg    <= sm6_reg;
            below7_reg <= below6_reg;
            above7_reg <= above6_reg;
            b7_reg     <= b6_reg;
            nm7_reg    <= nm6_reg;
            pb7_reg    <= pb7_next;
        end
        if (ctrl.load[7])
        begin
            p8_reg  <= p8_next;
            v8_reg  <= v8_next;
            sm8_reg <= sm7_reg;
        end
    end

    assign new_pos    = p8_reg;
    assign new_vel    = v8_reg;
    assign new_smooth = sm8_reg;

endmodule

// File: design/particle_integrate_and_bound.sv
// Top level of the particle integrate-and-bound block: configuration
// registers, pipeline control and three axis datapaths. Depends on pib_pkg,
// pib_pipe_ctrl, pib_axis and particle_integrate_and_bound_defines.svh.
//
// One particle transfer in, one result transfer out. The block takes a particle
// in every cycle when the output side keeps up, and returns its result from the
// last stage; the depth is set by the chain of four dependent multiplies per axis
// (acceleration by dt, velocity by dt, then restitution applied twice for a box
// whose lower bound lies above its upper bound), each followed by a register.
// Stalled stages hold their contents and empty stages keep filling, so the
// input stays ready while a result waits unless all eight stages are full.
// Configuration writes take effect at once and belong while no particle is in
// flight.
`include "particle_integrate_and_bound_defines.svh"

module particle_integrate_and_bound (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 particle_valid,
    output logic                                 particle_ready,
    input  pib_pkg::particle_t                   particle,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output pib_pkg::result_t                     result,
    input  logic                                 cfg_we,
    input  logic [pib_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pib_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pib_pkg::*;

    logic [15:0]        time_step_reg,   time_step_next;
    logic [16:0]        restitution_reg, restitution_next;
    logic signed [31:0] x_lower_reg, x_lower_next, x_upper_reg, x_upper_next;
    logic signed [31:0] y_lower_reg, y_lower_next, y_upper_reg, y_upper_next;
    logic signed [31:0] z_lower_reg, z_lower_next, z_upper_reg, z_upper_next;

    pipe_ctrl_t ctrl;

    // Configuration register decode.
    always_comb
    begin
        time_step_next   = time_step_reg;
        restitution_next = restitution_reg;
        x_lower_next     = x_lower_reg;
        x_upper_next     = x_upper_reg;
        y_lower_next     = y_lower_reg;
        y_upper_next     = y_upper_reg;
        z_lower_next     = z_lower_reg;
        z_upper_next     = z_upper_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME_STEP:   time_step_next   = cfg_data[15:0];
                CFG_RESTITUTION: restitution_next = cfg_data[16:0];
                CFG_X_LOWER:     x_lower_next     = $signed(cfg_data);
                CFG_X_UPPER:     x_upper_next     = $signed(cfg_data);
                CFG_Y_LOWER:     y_lower_next     = $signed(cfg_data);
                CFG_Y_UPPER:     y_upper_next     = $signed(cfg_data);
                CFG_Z_LOWER:     z_lower_next     = $signed(cfg_data);
                CFG_Z_UPPER:     z_upper_next     = $signed(cfg_data);
                default:         time_step_next   = time_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= TIME_STEP_RST;
            restitution_reg <= RESTITUTION_RST;
            x_lower_reg     <= LOWER_RST;
            x_upper_reg     <= UPPER_RST;
            y_lower_reg     <= LOWER_RST;
            y_upper_reg     <= UPPER_RST;
            z_lower_reg     <= LOWER_RST;
            z_upper_reg     <= UPPER_RST;
        end
        else
        begin
            time_step_reg   <= time_step_next;
            restitution_reg <= restitution_next;
            x_lower_reg     <= x_lower_next;
            x_upper_reg     <= x_upper_next;
            y_lower_reg     <= y_lower_next;
            y_upper_reg     <= y_upper_next;
            z_lower_reg     <= z_lower_next;
            z_upper_reg     <= z_upper_next;
        end
    end

    // Pipeline occupancy and stage load enables.
    pib_pipe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (particle_valid),
        .up_ready   (particle_ready),
        .down_valid (result_valid),
        .down_ready (result_ready),
        .ctrl       (ctrl)
    );

    // One datapath per axis.
    pib_axis u_axis_x (
        .clk         (clk),
        .ctrl        (ctrl),
        .time_step   (time_step_reg),
        .restitution (restitution_reg),
        .lower       (x_lower_reg),
        .upper       (x_upper_reg),
        .pos         (particle.pos_x),
        .vel         (particle.vel_x),
        .acc         (particle.acc_x),
        .smooth      (particle.smooth_vx),
        .new_pos     (result.new_pos_x),
        .new_vel     (result.new_vel_x),
        .new_smooth  (result.new_smooth_vx)
    );

    pib_axis u_axis_y (
        .clk         (clk),
        .ctrl        (ctrl),
        .time_step   (time_step_reg),
        .restitution (restitution_reg),
        .lower       (y_lower_reg),
        .upper       (y_upper_reg),
        .pos         (particle.pos_y),
        .vel         (particle.vel_y),
        .acc         (particle.acc_y),
        .smooth      (particle.smooth_vy),
        .new_pos     (result.new_pos_y),
        .new_vel     (result.new_vel_y),
        .new_smooth  (result.new_smooth_vy)
    );

    pib_axis u_axis_z (
        .clk         (clk),
        .ctrl        (ctrl),
        .time_step   (time_step_reg),
        .restitution (restitution_reg),
        .lower       (z_lower_reg),
        .upper       (z_upper_reg),
        .pos         (particle.pos_z),
        .vel         (particle.vel_z),
        .acc         (particle.acc_z),
        .smooth      (particle.smooth_vz),
        .new_pos     (result.new_pos_z),
        .new_vel     (result.new_vel_z),
        .new_smooth  (result.new_smooth_vz)
    );

    // A finished position never lies above its upper bound.
    `PIB_ASSERT_ALWAYS(a_x_in_box, !result_valid || (result.new_pos_x <= x_upper_reg))
    `PIB_ASSERT_ALWAYS(a_z_in_box, !result_valid || (result.new_pos_z <= z_upper_reg))
    // With no result waiting, every stage can move, so the input is ready.
    `PIB_ASSERT_ALWAYS(a_drain_ready, result_valid || particle_ready)
    // An accepted particle occupies the first stage in the next cycle.
    `PIB_ASSERT_NEXT(a_first_stage, particle_valid && particle_ready, ctrl.valid[0])

endmodule
